/* rtl/hes_pkg.sv */
// Shared types and constants for the hopper eject delivery sequencer.
// Holds the request/result payload structs, request and phase codes, register map.
// No dependencies.
`timescale 1ns / 1ps

package hes_pkg;

    // Request codes carried in req_type
    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_START   = 3'd1,
        REQ_ENABLE  = 3'd2,
        REQ_DISABLE = 3'd3,
        REQ_INIT    = 3'd4
    } req_code_t;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_READY = 2'd1,
        PH_EJECT      = 2'd2,
        PH_WAIT_DELIV = 2'd3
    } phase_t;

    // Configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_PULSE    = 2'd0;
    localparam logic [1:0] REG_DELIVERY = 2'd1;
    localparam logic [1:0] REG_RUN      = 2'd2;

    localparam int unsigned ADDR_W = 4;

    localparam logic [15:0] PULSE_RST    = 16'd50;
    localparam logic [15:0] DELIVERY_RST = 16'd1000;
    localparam logic [15:0] RUN_RST      = 16'd5000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic        ball_ready_level;
        logic        ball_delivered_level;
        logic        continuous_mode;
    } req_t;

    typedef struct packed {
        logic   solenoid_drive;
        logic   running;
        logic   enabled_flag;
        phase_t phase;
        logic   run_timed_out;
        logic   ball_delivered_now;
    } rsp_t;

    typedef struct packed {
        logic [15:0] solenoid_pulse_ms;
        logic [15:0] delivery_timeout_ms;
        logic [15:0] run_timeout_ms;
    } cfg_t;

endpackage

/* rtl/hes_apb_regs.sv */
// APB configuration registers for the hopper eject delivery sequencer.
// Depends on hes_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module hes_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hes_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output hes_pkg::cfg_t               cfg
);

    logic [15:0] pulse_reg;
    logic [15:0] delivery_reg;
    logic [15:0] run_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg    <= hes_pkg::PULSE_RST;
            delivery_reg <= hes_pkg::DELIVERY_RST;
            run_reg      <= hes_pkg::RUN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                hes_pkg::REG_PULSE:    pulse_reg    <= pwdata[15:0];
                hes_pkg::REG_DELIVERY: delivery_reg <= pwdata[15:0];
                hes_pkg::REG_RUN:      run_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            hes_pkg::REG_PULSE:    prdata = {16'd0, pulse_reg};
            hes_pkg::REG_DELIVERY: prdata = {16'd0, delivery_reg};
            hes_pkg::REG_RUN:      prdata = {16'd0, run_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.solenoid_pulse_ms   = pulse_reg;
    assign cfg.delivery_timeout_ms = delivery_reg;
    assign cfg.run_timeout_ms      = run_reg;

endmodule

/* rtl/hes_core.sv */
// Sequencer state and single-pass step logic for one request.
// Depends on hes_pkg for req_t, rsp_t, cfg_t and the phase/request codes.
`timescale 1ns / 1ps

module hes_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  hes_pkg::req_t req,
    input  hes_pkg::cfg_t cfg,
    output hes_pkg::rsp_t rsp
);

    hes_pkg::phase_t phase_reg,  phase_next;
    logic            enable_reg, enable_next;
    logic            running_reg, running_next;
    logic            loop_reg,   loop_next;
    logic            coil_reg,   coil_next;
    logic [31:0]     run_stamp_reg,   run_stamp_next;
    logic [31:0]     phase_stamp_reg, phase_stamp_next;
    logic [31:0]     kick_stamp_reg,  kick_stamp_next;

    logic [31:0] run_elapsed;
    logic [31:0] phase_elapsed;
    logic [31:0] kick_elapsed;
    logic        run_expired;
    logic        deliv_expired;
    logic        pulse_done;
    logic        tmo;
    logic        dlv;

    // Elapsed times wrap modulo 2^32
    assign run_elapsed   = req.now_ms - run_stamp_reg;
    assign phase_elapsed = req.now_ms - phase_stamp_reg;
    assign kick_elapsed  = req.now_ms - kick_stamp_reg;
    assign run_expired   = run_elapsed   >= {16'd0, cfg.run_timeout_ms};
    assign deliv_expired = phase_elapsed >= {16'd0, cfg.delivery_timeout_ms};
    assign pulse_done    = kick_elapsed  >= {16'd0, cfg.solenoid_pulse_ms};

    // Next state for the request at the input
    always_comb
    begin
        phase_next       = phase_reg;
        enable_next      = enable_reg;
        running_next     = running_reg;
        loop_next        = loop_reg;
        coil_next        = coil_reg;
        run_stamp_next   = run_stamp_reg;
        phase_stamp_next = phase_stamp_reg;
        kick_stamp_next  = kick_stamp_reg;
        tmo              = 1'b0;
        dlv              = 1'b0;

        case (req.req_type)
            hes_pkg::REQ_TICK:
            begin
                if (enable_reg)
                begin
                    // Overall run timeout wins over the phase logic
                    if (phase_reg != hes_pkg::PH_IDLE && run_expired)
                    begin
                        tmo              = 1'b1;
                        coil_next        = 1'b0;
                        run_stamp_next   = req.now_ms;
                        phase_stamp_next = req.now_ms;
                        if (loop_reg)
                        begin
                            phase_next = hes_pkg::PH_WAIT_READY;
                        end
                        else
                        begin
                            running_next = 1'b0;
                            phase_next   = hes_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            hes_pkg::PH_WAIT_READY:
                            begin
                                if (req.ball_ready_level)
                                begin
                                    coil_next       = 1'b1;
                                    kick_stamp_next = req.now_ms;
                                    phase_next      = hes_pkg::PH_EJECT;
                                end
                            end
                            hes_pkg::PH_EJECT:
                            begin
                                if (pulse_done)
                                begin
                                    coil_next        = 1'b0;
                                    phase_stamp_next = req.now_ms;
                                    phase_next       = hes_pkg::PH_WAIT_DELIV;
                                end
                            end
                            hes_pkg::PH_WAIT_DELIV:
                            begin
                                if (req.ball_delivered_level)
                                begin
                                    dlv              = 1'b1;
                                    run_stamp_next   = req.now_ms;
                                    phase_stamp_next = req.now_ms;
                                    if (loop_reg)
                                    begin
                                        phase_next = hes_pkg::PH_WAIT_READY;
                                    end
                                    else
                                    begin
                                        running_next = 1'b0;
                                        phase_next   = hes_pkg::PH_IDLE;
                                    end
                                end
                                else if (deliv_expired)
                                begin
                                    // Retry: go back and wait for another ball
                                    phase_stamp_next = req.now_ms;
                                    phase_next       = hes_pkg::PH_WAIT_READY;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            hes_pkg::REQ_START:
            begin
                kick_stamp_next  = 32'd0;
                coil_next        = 1'b0;
                phase_stamp_next = req.now_ms;
                phase_next       = hes_pkg::PH_WAIT_READY;
                loop_next        = req.continuous_mode;
                enable_next      = 1'b1;
                running_next     = 1'b1;
                run_stamp_next   = req.now_ms;
            end
            hes_pkg::REQ_ENABLE:
            begin
                enable_next = 1'b1;
            end
            hes_pkg::REQ_DISABLE:
            begin
                coil_next   = 1'b0;
                enable_next = 1'b0;
            end
            hes_pkg::REQ_INIT:
            begin
                kick_stamp_next  = 32'd0;
                phase_stamp_next = 32'd0;
                coil_next        = 1'b0;
                run_stamp_next   = req.now_ms;
                enable_next      = 1'b0;
                running_next     = 1'b0;
                phase_next       = hes_pkg::PH_IDLE;
            end
            default: ;
        endcase
    end

    // Commit state when the request advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= hes_pkg::PH_IDLE;
            enable_reg      <= 1'b0;
            running_reg     <= 1'b0;
            loop_reg        <= 1'b0;
            coil_reg        <= 1'b0;
            run_stamp_reg   <= 32'd0;
            phase_stamp_reg <= 32'd0;
            kick_stamp_reg  <= 32'd0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            enable_reg      <= enable_next;
            running_reg     <= running_next;
            loop_reg        <= loop_next;
            coil_reg        <= coil_next;
            run_stamp_reg   <= run_stamp_next;
            phase_stamp_reg <= phase_stamp_next;
            kick_stamp_reg  <= kick_stamp_next;
        end
    end

    // Result reflects the state after this request
    assign rsp.solenoid_drive     = coil_next;
    assign rsp.running            = running_next;
    assign rsp.enabled_flag       = enable_next;
    assign rsp.phase              = phase_next;
    assign rsp.run_timed_out      = tmo;
    assign rsp.ball_delivered_now = dlv;

endmodule

/* rtl/hopper_eject_delivery_sequencer.sv */
// Top level of the hopper eject delivery sequencer: input register, core, result register.
// Depends on hes_pkg, hes_apb_regs and hes_core.
`timescale 1ns / 1ps

// Ball-hopper solenoid sequencer. Each request (tick, start run, enable, disable,
// init) is taken into an input register, stepped through the sequencer state by
// combinational logic, and its status lands in a result register. One request is
// accepted every clock cycle while results are being taken; a result waits in the
// result register until it is taken. The rate rests on the combinational state
// update (three 32-bit wrap-around subtract-and-compare checks against the
// configured millisecond limits).
// Configuration over APB: 0x0 solenoid pulse, 0x4 delivery timeout, 0x8 run timeout,
// each 16 bits; write them only while no request is in flight.
module hopper_eject_delivery_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hes_pkg::req_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hes_pkg::rsp_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hes_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic          in_vld_reg;
    hes_pkg::req_t in_data_reg;
    logic          out_vld_reg;
    hes_pkg::rsp_t out_data_reg;
    logic          advance;
    hes_pkg::cfg_t cfg;
    hes_pkg::rsp_t rsp;

    hes_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hes_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (in_data_reg),
        .cfg     (cfg),
        .rsp     (rsp)
    );

    // Advance the held request when the result register can take it
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // The solenoid is only ever energized while ejecting
    a_coil_in_eject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.solenoid_drive) |-> (out_data.phase == hes_pkg::PH_EJECT))
        else $error("solenoid driven outside the eject phase");

    // Any active phase belongs to a run
    a_phase_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.phase != hes_pkg::PH_IDLE) |-> out_data.running)
        else $error("active phase without a run in progress");

    // Timeout and delivery never report on the same request
    a_tmo_dlv_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.run_timed_out && out_data.ball_delivered_now))
        else $error("timeout and delivery on one request");

    // A delivery ends the cycle in idle or wait ready
    a_dlv_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.ball_delivered_now) |->
            (out_data.phase == hes_pkg::PH_IDLE || out_data.phase == hes_pkg::PH_WAIT_READY))
        else $error("delivery left the sequencer in a busy phase");

endmodule

/* tb/sv/hes_status_checker.sv */
// Status checker for the hopper eject delivery sequencer: tracks register writes,
// predicts the status of every accepted request and compares it with the block's result.
// Depends on hes_pkg.
`timescale 1ns / 1ps

module hes_status_checker
    import hes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  req_t              in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  rsp_t              out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int unsigned       outstanding,
    output int unsigned       fail_count
);

    // Predicted sequencer state and limits
    phase_t      ph_q;
    logic        en_q;
    logic        run_on_q;
    logic        loop_q;
    logic        coil_q;
    logic [31:0] run_stamp;
    logic [31:0] phase_stamp;
    logic [31:0] kick_stamp;
    logic [15:0] pulse_lim;
    logic [15:0] deliv_lim;
    logic [15:0] run_lim;

    rsp_t        status_queue[$];
    rsp_t        want;
    int unsigned errors;
    int unsigned results_seen;

    // Advance the predicted state by one request and form its status
    task automatic step_sequencer(input req_t r, output rsp_t s);
        logic timed_out;
        logic delivered_now;
        timed_out     = 1'b0;
        delivered_now = 1'b0;
        case (r.req_type)
            REQ_TICK:
            begin
                if (en_q)
                begin
                    if (ph_q != PH_IDLE && (r.now_ms - run_stamp) >= {16'd0, run_lim})
                    begin
                        // whole eject cycle ran too long: drop coil, restart or stop
                        coil_q      = 1'b0;
                        run_stamp   = r.now_ms;
                        phase_stamp = r.now_ms;
                        if (loop_q)
                            ph_q = PH_WAIT_READY;
                        else
                        begin
                            run_on_q = 1'b0;
                            ph_q     = PH_IDLE;
                        end
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        case (ph_q)
                            PH_WAIT_READY:
                            begin
                                if (r.ball_ready_level)
                                begin
                                    coil_q     = 1'b1;
                                    kick_stamp = r.now_ms;
                                    ph_q       = PH_EJECT;
                                end
                            end
                            PH_EJECT:
                            begin
                                if ((r.now_ms - kick_stamp) >= {16'd0, pulse_lim})
                                begin
                                    coil_q      = 1'b0;
                                    phase_stamp = r.now_ms;
                                    ph_q        = PH_WAIT_DELIV;
                                end
                            end
                            PH_WAIT_DELIV:
                            begin
                                if (r.ball_delivered_level)
                                begin
                                    delivered_now = 1'b1;
                                    run_stamp     = r.now_ms;
                                    phase_stamp   = r.now_ms;
                                    if (loop_q)
                                        ph_q = PH_WAIT_READY;
                                    else
                                    begin
                                        run_on_q = 1'b0;
                                        ph_q     = PH_IDLE;
                                    end
                                end
                                else if ((r.now_ms - phase_stamp) >= {16'd0, deliv_lim})
                                begin
                                    // no delivery seen in time: look for a ball again
                                    phase_stamp = r.now_ms;
                                    ph_q        = PH_WAIT_READY;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            REQ_START:
            begin
                kick_stamp  = '0;
                coil_q      = 1'b0;
                phase_stamp = r.now_ms;
                ph_q        = PH_WAIT_READY;
                loop_q      = r.continuous_mode;
                en_q        = 1'b1;
                run_on_q    = 1'b1;
                run_stamp   = r.now_ms;
            end
            REQ_ENABLE:
                en_q = 1'b1;
            REQ_DISABLE:
            begin
                coil_q = 1'b0;
                en_q   = 1'b0;
            end
            REQ_INIT:
            begin
                kick_stamp  = '0;
                phase_stamp = '0;
                coil_q      = 1'b0;
                run_stamp   = r.now_ms;
                en_q        = 1'b0;
                run_on_q    = 1'b0;
                ph_q        = PH_IDLE;
            end
            default:
            begin
            end
        endcase
        s.solenoid_drive     = coil_q;
        s.running            = run_on_q;
        s.enabled_flag       = en_q;
        s.phase              = ph_q;
        s.run_timed_out      = timed_out;
        s.ball_delivered_now = delivered_now;
    endtask

    // Count a failure; report only the first few
    task automatic note_mismatch(input string what, input logic [1:0] exp,
                                 input logic [1:0] act);
        errors++;
        if (errors <= 10)
            $display("status %0d: %s expected %0d got %0d", results_seen, what, exp, act);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_q         = PH_IDLE;
            en_q         = 1'b0;
            run_on_q     = 1'b0;
            loop_q       = 1'b0;
            coil_q       = 1'b0;
            run_stamp    = '0;
            phase_stamp  = '0;
            kick_stamp   = '0;
            pulse_lim    = PULSE_RST;
            deliv_lim    = DELIVERY_RST;
            run_lim      = RUN_RST;
            errors       = 0;
            results_seen = 0;
            status_queue.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_PULSE:    pulse_lim = pwdata[15:0];
                    REG_DELIVERY: deliv_lim = pwdata[15:0];
                    REG_RUN:      run_lim   = pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end

            // compare each result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (status_queue.size() == 0)
                    note_mismatch("status with none pending", 2'd0, 2'd0);
                else
                begin
                    want = status_queue.pop_front();
                    if (want.solenoid_drive !== out_data.solenoid_drive)
                        note_mismatch("solenoid_drive", want.solenoid_drive,
                                      out_data.solenoid_drive);
                    if (want.running !== out_data.running)
                        note_mismatch("running", want.running, out_data.running);
                    if (want.enabled_flag !== out_data.enabled_flag)
                        note_mismatch("enabled_flag", want.enabled_flag,
                                      out_data.enabled_flag);
                    if (want.phase !== out_data.phase)
                        note_mismatch("phase", want.phase, out_data.phase);
                    if (want.run_timed_out !== out_data.run_timed_out)
                        note_mismatch("run_timed_out", want.run_timed_out,
                                      out_data.run_timed_out);
                    if (want.ball_delivered_now !== out_data.ball_delivered_now)
                        note_mismatch("ball_delivered_now", want.ball_delivered_now,
                                      out_data.ball_delivered_now);
                end
                results_seen++;
            end

            // predict each accepted request
            if (in_valid && in_ready)
            begin
                step_sequencer(in_data, want);
                status_queue.push_back(want);
            end

            outstanding <= status_queue.size();
            fail_count  <= errors;
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the hopper eject delivery sequencer: clock, reset, request and
// register stimulus, result stalls and the verdict. Depends on hes_pkg,
// hes_status_checker and hopper_eject_delivery_sequencer.
`timescale 1ns / 1ps

module tb;
    import hes_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 275;
    localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    req_t                in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rsp_t                out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    int unsigned         outstanding;
    int unsigned         fail_count;
    int unsigned         cycles;
    int unsigned         burst_left;
    int unsigned         step_max;
    logic [31:0]         sim_ms;

    hopper_eject_delivery_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    hes_status_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t request_of(input logic [2:0] code, input logic [31:0] t,
                                        input logic rdy, input logic dlv, input logic cont);
        req_t r;
        r.req_type             = code;
        r.now_ms               = t;
        r.ball_ready_level     = rdy;
        r.ball_delivered_level = dlv;
        r.continuous_mode      = cont;
        return r;
    endfunction

    // Mostly ticks on an advancing clock, with runs started now and then
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(0, 199);
        if (pick < 8)
            r.req_type = REQ_START;
        else if (pick < 12)
            r.req_type = REQ_ENABLE;
        else if (pick < 16)
            r.req_type = REQ_DISABLE;
        else if (pick < 19)
            r.req_type = REQ_INIT;
        else if (pick < 21)
            r.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        else
            r.req_type = REQ_TICK;
        // occasional jump anywhere, including across the wrap
        if ($urandom_range(0, 49) == 0)
            sim_ms = $urandom();
        else
            sim_ms = sim_ms + $urandom_range(0, step_max);
        r.now_ms               = sim_ms;
        r.ball_ready_level     = ($urandom_range(0, 4) < 2);
        r.ball_delivered_level = ($urandom_range(0, 2) == 0);
        r.continuous_mode      = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Offer one request in bursts with random gaps; returns at the accepting edge
    task automatic offer(input req_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    // Setup then access cycle; the register takes the value at the edge that ends the access cycle
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and let every pending status come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Result side: changing stall patterns plus a periodic long hold-off
    initial
    begin
        int unsigned tick_no;
        int unsigned hold_left;
        logic [15:0] pattern;
        tick_no   = 0;
        hold_left = 0;
        pattern   = 16'hFFFF;
        forever
        begin
            @(posedge clk);
            tick_no++;
            if (tick_no % 512 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pattern = 16'hFFFF;
                    1: pattern = 16'($urandom()) | 16'h8001;
                    2: pattern = (16'($urandom()) & 16'($urandom())) | 16'h0100;
                    default: pattern = 16'h0FF0;
                endcase
            end
            if (tick_no % 3000 == 700)
                hold_left = 300;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= pattern[tick_no % 16];
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL hopper_eject_delivery_sequencer");
        $finish;
    end

    initial
    begin
        int          k;
        int          n;
        int          c;
        logic [15:0] run_pick;
        burst_left = 0;
        step_max   = 400;
        sim_ms     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the sequencer at reset limits (50 / 1000 / 5000)
        offer(request_of(REQ_TICK,    32'd0,          1'b1, 1'b1, 1'b0)); // disabled tick
        offer(request_of(REQ_ENABLE,  32'd0,          1'b0, 1'b0, 1'b0));
        offer(request_of(REQ_TICK,    32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1)); // idle tick
        offer(request_of(REQ_START,   32'd100,        1'b0, 1'b0, 1'b1));
        offer(request_of(REQ_TICK,    32'd110,        1'b0, 1'b0, 1'b0));
        offer(request_of(REQ_TICK,    32'd120,        1'b1, 1'b0, 1'b0)); // kick
        offer(request_of(REQ_TICK,    32'd150,        1'b0, 1'b0, 1'b0));
        offer(request_of(REQ_TICK,    32'd170,        1'b0, 1'b0, 1'b0)); // pulse done
        offer(request_of(REQ_TICK,    32'd180,        1'b0, 1'b1, 1'b0)); // delivered
        offer(request_of(REQ_TICK,    32'd200,        1'b1, 1'b0, 1'b0));
        offer(request_of(REQ_START,   32'd210,        1'b0, 1'b0, 1'b0)); // coil off
        offer(request_of(REQ_TICK,    32'd220,        1'b1, 1'b0, 1'b0));
        offer(request_of(REQ_TICK,    32'd270,        1'b0, 1'b0, 1'b0));
        offer(request_of(REQ_TICK,    32'd1270,       1'b0, 1'b0, 1'b0)); // no delivery
        offer(request_of(REQ_TICK,    32'd5210,       1'b0, 1'b0, 1'b0)); // run limit
        offer(request_of(REQ_START,   32'hFFFF_FF00,  1'b0, 1'b0, 1'b1));
        offer(request_of(REQ_TICK,    32'hFFFF_FF10,  1'b1, 1'b0, 1'b0));
        offer(request_of(REQ_DISABLE, 32'hFFFF_FF20,  1'b1, 1'b1, 1'b1));
        offer(request_of(REQ_TICK,    32'hFFFF_FF30,  1'b1, 1'b1, 1'b0));
        offer(request_of(REQ_ENABLE,  32'hFFFF_FF40,  1'b0, 1'b0, 1'b0));
        offer(request_of(REQ_TICK,    32'h0000_1300,  1'b1, 1'b1, 1'b1)); // wrapped limit
        offer(request_of(REQ_INIT,    32'h1234_5678,  1'b1, 1'b1, 1'b1));
        for (c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++)
            offer(request_of(3'(c), 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        wait_idle();

        // Random phases, each under its own limits
        for (k = 0; k < 6; k++)
        begin
            case (k)
                1:
                begin
                    write_register(REG_PULSE, 16'd0);
                    write_register(REG_DELIVERY, 16'd0);
                    write_register(REG_RUN, 16'hFFFF);
                    step_max = 3000;
                end
                2:
                begin
                    write_register(REG_PULSE, 16'hFFFF);
                    write_register(REG_DELIVERY, 16'hFFFF);
                    write_register(REG_RUN, 16'hFFFF);
                    step_max = 4000;
                end
                3:
                begin
                    write_register(REG_PULSE, 16'd0);
                    write_register(REG_DELIVERY, 16'd0);
                    write_register(REG_RUN, 16'd0);
                    step_max = 10;
                end
                4:
                begin
                    run_pick = 16'($urandom_range(500, 10000));
                    write_register(REG_PULSE, 16'($urandom_range(1, 200)));
                    write_register(REG_DELIVERY, 16'($urandom_range(1, 2000)));
                    write_register(REG_RUN, run_pick);
                    step_max = run_pick / 10;
                end
                5:
                begin
                    write_register(REG_PULSE, 16'd3);
                    write_register(REG_DELIVERY, 16'd20);
                    write_register(REG_RUN, 16'd150);
                    step_max = 15;
                end
                default:
                    step_max = 400;
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                offer(random_request());
            wait_idle();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("PASS hopper_eject_delivery_sequencer");
        else
            $display("FAIL hopper_eject_delivery_sequencer");
        $finish;
    end

endmodule
